/* sv/c3f_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared constants and types of the 3x3 image filter: register map, kernel
// codes, field widths and the structs passed between the pipeline parts.
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int KSEL_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int WIN_N   = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_IDX_KSEL   = 2'd2;

  localparam int CFG_WIDTH_RESET  = 640;
  localparam int CFG_HEIGHT_RESET = 480;

  // kernel codes; any other code runs the blur
  localparam logic [KSEL_W-1:0] KSEL_BLUR    = 2'd0;
  localparam logic [KSEL_W-1:0] KSEL_SHARPEN = 2'd1;
  localparam logic [KSEL_W-1:0] KSEL_LAPLACE = 2'd2;

  // one column of the 3x3 window
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  // per-request control that travels with a pixel down the pipeline
  typedef struct packed {
    logic emit;
    logic last;
    logic top_edge;
    logic bot_edge;
    logic left_edge;
    logic right_edge;
  } meta_t;

endpackage

/* sv/c3f_line_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3f_line_buf
// Two-line pixel store, one entry per column holding the pixels of the two
// previous rows. Registered read, read-modify-write bypass, clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module c3f_line_buf
  import c3f_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [2*PIX_W-1:0]    rd_data,
  input  logic                  wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [2*PIX_W-1:0]    wr_data,
  output logic                  clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [2*PIX_W-1:0] line_store [DEPTH];
  logic [2*PIX_W-1:0] mem_q;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd;
  logic [AW-1:0]      clr_addr;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      line_store[clr_addr] <= '0;
    end else if (wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= line_store[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // take the word being written when a read hits the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

/* sv/c3f_win_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3f_win_cell
// One column cell of the 3x3 window; takes its neighbor's column on a shift.
// ----------------------------------------------------------------------------
module c3f_win_cell
  import c3f_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift,
  input  pix_col_t col_in,
  output pix_col_t col_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

endmodule

/* sv/c3f_kernel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3f_kernel
// Edge masking, 3x3 weighted sum, rounding and saturation, output register.
// ----------------------------------------------------------------------------
module c3f_kernel
  import c3f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  meta_t                 meta,
  input  pix_col_t [WIN_N-1:0]  win,
  input  logic [KSEL_W-1:0]     ksel,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  frame_last
);

  logic [PIX_W-1:0]  t00, t01, t02, t10, t11, t12, t20, t21, t22;
  logic [11:0]       blur_sum;
  logic [PIX_W-1:0]  blur_q;
  logic              blur_inc;
  logic [PIX_W:0]    blur_rnd;
  logic [11:0]       center;
  logic signed [11:0] lap_acc;
  logic [PIX_W-1:0]  res;

  always_comb begin
    // zero every tap that falls outside the frame
    t00 = (meta.top_edge || meta.left_edge)  ? '0 : win[0].top;
    t01 = meta.top_edge                      ? '0 : win[1].top;
    t02 = (meta.top_edge || meta.right_edge) ? '0 : win[2].top;
    t10 = meta.left_edge                     ? '0 : win[0].mid;
    t11 = win[1].mid;
    t12 = meta.right_edge                    ? '0 : win[2].mid;
    t20 = (meta.bot_edge || meta.left_edge)  ? '0 : win[0].bot;
    t21 = meta.bot_edge                      ? '0 : win[1].bot;
    t22 = (meta.bot_edge || meta.right_edge) ? '0 : win[2].bot;

    blur_sum = 12'(t00) + 12'(t02) + 12'(t20) + 12'(t22)
             + {3'b0, t01, 1'b0} + {3'b0, t10, 1'b0}
             + {3'b0, t12, 1'b0} + {3'b0, t21, 1'b0}
             + {2'b0, t11, 2'b0};
    blur_q   = blur_sum[11:4];
    blur_inc = (blur_sum[3:0] > 4'd8) || (blur_sum[3:0] == 4'd8 && blur_q[0]);
    blur_rnd = {1'b0, blur_q} + (PIX_W + 1)'(blur_inc);

    center = (ksel == KSEL_SHARPEN) ? ({2'b0, t11, 2'b0} + 12'(t11))
                                    : {2'b0, t11, 2'b0};
    lap_acc = $signed(center) - $signed(12'(t01)) - $signed(12'(t10))
            - $signed(12'(t12)) - $signed(12'(t21));

    case (ksel)
      KSEL_SHARPEN, KSEL_LAPLACE: begin
        if (lap_acc < 0) begin
          res = '0;
        end else if (lap_acc > 12'sd255) begin
          res = '1;
        end else begin
          res = lap_acc[PIX_W-1:0];
        end
      end
      default: begin
        res = blur_rnd[PIX_W] ? '1 : blur_rnd[PIX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_vld && meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out  <= res;
      frame_last <= meta.last;
    end
  end

endmodule

/* sv/conv3x3_image_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster pixel stream with zero padding: Gaussian
// blur, sharpen or Laplacian, rounded half to even and saturated to 8 bits.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   --------  ---------  ---------------------  ---------------------------
//   input     in         in_valid / in_stall    pixel_in
//   output    out        out_valid / out_stall  pixel_out, frame_last
//   config    in / out   APB psel/penable/...   0x0 width, 0x4 height, 0x8 kernel
//
// One pixel request per clock while in_stall is low. A result appears once
// the request W+1 places later has passed the line store read, the window
// and the kernel register. After reset the line store is swept to zero,
// during which in_stall is high; configuration writes are taken as usual.
// The pipeline holds as a whole while a result waits on out_stall; a waiting
// result does not block the next request when the output is taken that cycle.
//
module conv3x3_image_filter
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   pixel_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   pixel_out,
  output logic               frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);       // line store address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // column count and width
  localparam int RW = $clog2(MAX_HEIGHT + 3);  // row count, room for drain rows
  localparam int W_RST = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int H_RST = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  // --------------------------------------------------------------------------
  // Configuration registers: raw value for readback, clamped copy for use
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  width_raw;
  logic [DIM_W-1:0]  height_raw;
  logic [KSEL_W-1:0] kernel_sel;
  logic [WW-1:0]     w_dim;
  logic [RW-1:0]     h_dim;
  logic              cfg_wr;
  logic [31:0]       wr_dim;
  logic [WW-1:0]     w_clamp;
  logic [RW-1:0]     h_clamp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    wr_dim = 32'(pwdata[DIM_W-1:0]);
    // clamp a written dimension into 1..MAX
    if (wr_dim == 32'd0) begin
      w_clamp = WW'(1);
      h_clamp = RW'(1);
    end else begin
      w_clamp = (wr_dim > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(wr_dim);
      h_clamp = (wr_dim > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(wr_dim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= DIM_W'(CFG_WIDTH_RESET);
      height_raw <= DIM_W'(CFG_HEIGHT_RESET);
      kernel_sel <= KSEL_BLUR;
      w_dim      <= WW'(W_RST);
      h_dim      <= RW'(H_RST);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IDX_WIDTH: begin
          width_raw <= pwdata[DIM_W-1:0];
          w_dim     <= w_clamp;
        end
        REG_IDX_HEIGHT: begin
          height_raw <= pwdata[DIM_W-1:0];
          h_dim      <= h_clamp;
        end
        REG_IDX_KSEL: begin
          kernel_sel <= pwdata[KSEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IDX_WIDTH:  prdata = DATA_W'(width_raw);
      REG_IDX_HEIGHT: prdata = DATA_W'(height_raw);
      REG_IDX_KSEL:   prdata = DATA_W'(kernel_sel);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe moves when the output slot is free
  // or being taken this cycle
  // --------------------------------------------------------------------------
  logic adv;
  logic accept;
  logic clearing;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || clearing;
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Stage 0: raster counters, window centre position and frame edge flags
  // --------------------------------------------------------------------------
  logic [WW-1:0]    col;
  logic [RW-1:0]    row;
  logic             restart;
  logic [WW-1:0]    c;
  logic [RW-1:0]    r;
  logic [PIX_W-1:0] x;
  logic [WW-1:0]    cc;
  logic [RW-1:0]    cr;
  logic             ctr_vld;
  meta_t            meta0;

  always_comb begin
    // restart when a shape change leaves the counters outside frame plus drain
    restart = (col >= w_dim) || (row > h_dim + RW'(1))
           || (row == h_dim + RW'(1) && col != '0);
    c = restart ? '0 : col;
    r = restart ? '0 : row;
    // drain rows feed zeros
    x = (r < h_dim) ? pixel_in : '0;

    if (c != '0) begin
      cc      = c - WW'(1);
      ctr_vld = (r != '0);
      cr      = r - RW'(1);
    end else begin
      cc      = w_dim - WW'(1);
      ctr_vld = (r >= RW'(2));
      cr      = r - RW'(2);
    end

    meta0.emit       = ctr_vld && (cr < h_dim);
    meta0.last       = meta0.emit && (cr == h_dim - RW'(1)) && (cc == w_dim - WW'(1));
    meta0.top_edge   = (cr == '0);
    meta0.bot_edge   = (cr == h_dim - RW'(1));
    meta0.left_edge  = (cc == '0);
    meta0.right_edge = (cc == w_dim - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (meta0.last) begin
        // frame done: start the next one
        col <= '0;
        row <= '0;
      end else if (c == w_dim - WW'(1)) begin
        col <= '0;
        row <= r + RW'(1);
      end else begin
        col <= c + WW'(1);
        row <= r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store read data arrives; write back the shifted pair
  // --------------------------------------------------------------------------
  logic             s1_valid;
  meta_t            s1_meta;
  logic [PIX_W-1:0] s1_x;
  logic [CW-1:0]    s1_addr;
  logic [2*PIX_W-1:0] lb_rd;
  logic [2*PIX_W-1:0] lb_wr;
  logic             lb_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta0;
      s1_x    <= x;
      s1_addr <= c[CW-1:0];
    end
  end

  // entry holds {row above, current row}; shift the column down by one row
  assign lb_we = s1_valid && adv;
  assign lb_wr = {lb_rd[PIX_W-1:0], s1_x};

  c3f_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (c[CW-1:0]),
    .rd_data  (lb_rd),
    .wr_en    (lb_we),
    .wr_addr  (s1_addr),
    .wr_data  (lb_wr),
    .clearing (clearing)
  );

  // --------------------------------------------------------------------------
  // Stage 2: window cells; the newest column enters at the right
  // --------------------------------------------------------------------------
  logic                 s2_valid;
  meta_t                s2_meta;
  pix_col_t             new_col;
  pix_col_t [WIN_N-1:0] win;

  assign new_col.top = lb_rd[2*PIX_W-1:PIX_W];
  assign new_col.mid = lb_rd[PIX_W-1:0];
  assign new_col.bot = s1_x;

  for (genvar k = 0; k < WIN_N; k++) begin : g_cell
    if (k == WIN_N - 1) begin : g_head
      c3f_win_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (lb_we),
        .col_in (new_col),
        .col_q  (win[k])
      );
    end else begin : g_body
      c3f_win_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (lb_we),
        .col_in (win[k+1]),
        .col_q  (win[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta <= s1_meta;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: kernel arithmetic into the output register
  // --------------------------------------------------------------------------
  c3f_kernel u_kernel (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (s2_valid),
    .meta       (s2_meta),
    .win        (win),
    .ksel       (kernel_sel),
    .out_valid  (out_valid),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule
